/* rtl/framed_line_packet_receiver_core_defines.svh */
// Assertion macros for the framed line packet receiver.
// No dependencies; included by the modules that carry assertions.
`ifndef FRAMED_LINE_PACKET_RECEIVER_CORE_DEFINES_SVH
`define FRAMED_LINE_PACKET_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FLPR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define FLPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define FLPR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FLPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/flpr_pkg.sv */
// Types and constants of the framed line packet receiver.
// No dependencies; imported by the receiver core and the testbench.
`default_nettype none

package flpr_pkg;

   typedef enum logic [3:0] {
      ST_LOOKING = 4'b0001,
      ST_HEADER  = 4'b0010,
      ST_DATA    = 4'b0100,
      ST_READY   = 4'b1000
   } stage_type;

   typedef enum logic [1:0] {
      OP_RECEIVE     = 2'd0,
      OP_RESTART     = 2'd1,
      OP_READ_DATA   = 2'd2,
      OP_READ_HEADER = 2'd3
   } opcode_type;

   localparam logic [1:0] STAGE_CODE_LOOKING = 2'd0;
   localparam logic [1:0] STAGE_CODE_HEADER  = 2'd1;
   localparam logic [1:0] STAGE_CODE_DATA    = 2'd2;
   localparam logic [1:0] STAGE_CODE_READY   = 2'd3;

   localparam logic [1:0] REG_FRAME_CHAR  = 2'd0;
   localparam logic [1:0] REG_BUFFER_SIZE = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_MS  = 2'd2;

   localparam logic [7:0]  CHAR_LF           = 8'h0A;
   localparam logic [7:0]  CHAR_CR           = 8'h0D;
   localparam logic [7:0]  FRAME_CHAR_RESET  = 8'd36;
   localparam logic [8:0]  BUFFER_SIZE_RESET = 9'd256;
   localparam logic [15:0] TIMEOUT_MS_RESET  = 16'd10000;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [15:0] timeout_count;
      logic [8:0]  data_count;
      logic [3:0]  header_count;
      logic [15:0] checksum;
      logic        packet_error;
      logic [1:0]  stage;
      logic [7:0]  pass_byte;
   } rsp_fields_type;

   typedef struct packed {
      rsp_fields_type fields;
      logic           mem_sel;
   } snap_type;

   function automatic logic [1:0] stage_code(input stage_type s);
      logic [1:0] code;
      case (s)
         ST_LOOKING: code = STAGE_CODE_LOOKING;
         ST_HEADER:  code = STAGE_CODE_HEADER;
         ST_DATA:    code = STAGE_CODE_DATA;
         ST_READY:   code = STAGE_CODE_READY;
         default:    code = STAGE_CODE_LOOKING;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

/* rtl/framed_line_packet_receiver_core.sv */
// Framed line packet receiver: byte-serial packet framing, header and data stores.
// Depends on flpr_pkg and framed_line_packet_receiver_core_defines.svh.
//
// Takes one item per clock with no stall of its own while the result side is not
// backed up; a result goes through the snapshot stage, then the output register, which
// also takes the registered read of the data store. The output register and the
// snapshot stage keep the input side open while a result waits. No clearing pass after
// reset: both stores are undefined until written. Configuration by APB at byte
// addresses 0 (frame_char), 4 (buffer_size) and 8 (timeout_ms).
`default_nettype none
`include "framed_line_packet_receiver_core_defines.svh"

module framed_line_packet_receiver_core
   import flpr_pkg::*;
#(
   parameter int HEADER_SIZE = 8,
   parameter int BUF_DEPTH   = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [47:0] req_tdata,   // rx_byte, tick_ms, read_index
   input  wire logic [1:0]  req_tuser,   // opcode
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // pass_byte, stage, packet_error, checksum, header_count, data_count,
   // timeout_count, read_data
   output      logic [63:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   localparam int HIDX_W  = $clog2(HEADER_SIZE + 1);
   localparam int HADDR_W = $clog2(HEADER_SIZE);
   localparam int DIDX_W  = $clog2(BUF_DEPTH + 1);
   localparam int DADDR_W = $clog2(BUF_DEPTH);
   localparam int LIM_W   = (DIDX_W > 9) ? DIDX_W : 9;

   logic [7:0]  frame_char_ff;
   logic [8:0]  buffer_size_ff;
   logic [15:0] timeout_ms_ff;

   stage_type         stage_ff, stage_in;
   logic [HIDX_W-1:0] hidx_ff, hidx_in;
   logic [DIDX_W-1:0] didx_ff, didx_in;
   logic [15:0]       sum_ff, sum_in;
   logic [31:0]       start_ff, start_in;
   logic [15:0]       tmo_ff, tmo_in;
   logic              err_ff, err_in;

   logic [7:0]         header_store_ff [HEADER_SIZE];
   logic               hs_we;
   logic [HADDR_W-1:0] hs_waddr;

   logic [7:0]         data_mem [BUF_DEPTH];
   logic               dm_we, dm_re;
   logic [DADDR_W-1:0] dm_waddr, dm_raddr;
   logic [7:0]         dm_rdata_ff;

   snap_type       snap_ff, snap_in;
   logic           snap_valid_ff, snap_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_fields_type rsp_ff, rsp_in;

   logic        acc, snap_adv, csr_wr;
   opcode_type  op;
   logic [7:0]  rx, ridx, pass, hdr_rd;
   logic [31:0] tick, elapsed;
   logic        mem_sel;
   logic [LIM_W-1:0] lim;

   assign rx   = req_tdata[7:0];
   assign tick = req_tdata[39:8];
   assign ridx = req_tdata[47:40];
   assign op   = opcode_type'(req_tuser);

   assign snap_adv      = snap_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready    = !snap_valid_ff || !rsp_valid_ff || rsp_tready;
   assign acc           = req_tvalid && req_tready;
   assign snap_valid_in = acc || (snap_valid_ff && !snap_adv);
   assign rsp_valid_in  = snap_adv || (rsp_valid_ff && !rsp_tready);

   assign elapsed = tick - start_ff;

   always_comb begin
      lim = LIM_W'(buffer_size_ff);
      if (lim == '0) begin
         lim = LIM_W'(1);
      end
      if (lim > LIM_W'(BUF_DEPTH)) begin
         lim = LIM_W'(BUF_DEPTH);
      end
   end

   always_comb begin
      stage_in = stage_ff;
      hidx_in  = hidx_ff;
      didx_in  = didx_ff;
      sum_in   = sum_ff;
      start_in = start_ff;
      tmo_in   = tmo_ff;
      err_in   = err_ff;
      hs_we    = 1'b0;
      hs_waddr = hidx_ff[HADDR_W-1:0];
      dm_we    = 1'b0;
      dm_waddr = didx_ff[DADDR_W-1:0];
      dm_re    = 1'b0;
      dm_raddr = DADDR_W'(ridx);
      pass     = 8'd0;
      hdr_rd   = 8'd0;
      mem_sel  = 1'b0;
      if (acc) begin
         case (op)
            OP_RECEIVE: begin
               if (rx == frame_char_ff) begin
                  if (stage_ff != ST_LOOKING) begin
                     err_in = 1'b1;
                  end
                  didx_in  = '0;
                  stage_in = ST_HEADER;
                  hs_we    = 1'b1;
                  hs_waddr = '0;
                  hidx_in  = HIDX_W'(1);
                  sum_in   = 16'd0;
                  start_in = tick;
               end else begin
                  case (stage_ff)
                     ST_LOOKING: begin
                        pass = rx;
                     end
                     ST_HEADER: begin
                        if (rx == CHAR_LF) begin
                           err_in   = 1'b1;
                           stage_in = ST_LOOKING;
                        end else begin
                           if (hidx_ff < HIDX_W'(HEADER_SIZE)) begin
                              hs_we   = 1'b1;
                              hidx_in = hidx_ff + HIDX_W'(1);
                              sum_in  = sum_ff + 16'(rx);
                           end
                           if (hidx_in >= HIDX_W'(HEADER_SIZE)) begin
                              didx_in  = '0;
                              stage_in = ST_DATA;
                           end
                        end
                     end
                     ST_DATA: begin
                        sum_in = sum_ff + 16'(rx);
                        if (didx_ff < DIDX_W'(BUF_DEPTH)) begin
                           dm_we   = 1'b1;
                           didx_in = didx_ff + DIDX_W'(1);
                        end
                        if (rx == CHAR_LF || rx == CHAR_CR || LIM_W'(didx_in) >= lim) begin
                           stage_in = ST_READY;
                        end
                     end
                     default: begin
                     end
                  endcase
                  if ((stage_in == ST_HEADER || stage_in == ST_DATA) &&
                      elapsed > 32'(timeout_ms_ff)) begin
                     if (tmo_ff != 16'hFFFF) begin
                        tmo_in = tmo_ff + 16'd1;
                     end
                     stage_in = ST_LOOKING;
                  end
               end
            end
            OP_RESTART: begin
               hidx_in  = '0;
               didx_in  = '0;
               sum_in   = 16'd0;
               stage_in = ST_LOOKING;
               tmo_in   = 16'd0;
            end
            OP_READ_DATA: begin
               if (32'(ridx) < BUF_DEPTH) begin
                  dm_re   = 1'b1;
                  mem_sel = 1'b1;
               end
            end
            OP_READ_HEADER: begin
               if (32'(ridx) < HEADER_SIZE) begin
                  hdr_rd = header_store_ff[ridx[HADDR_W-1:0]];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      snap_in.fields.read_data     = hdr_rd;
      snap_in.fields.timeout_count = tmo_in;
      snap_in.fields.data_count    = 9'(didx_in);
      snap_in.fields.header_count  = 4'(hidx_in);
      snap_in.fields.checksum      = sum_in;
      snap_in.fields.packet_error  = err_in;
      snap_in.fields.stage         = stage_code(stage_in);
      snap_in.fields.pass_byte     = pass;
      snap_in.mem_sel              = mem_sel;
      rsp_in = snap_ff.fields;
      if (snap_ff.mem_sel) begin
         rsp_in.read_data = dm_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff      <= ST_LOOKING;
         hidx_ff       <= '0;
         didx_ff       <= '0;
         sum_ff        <= 16'd0;
         start_ff      <= 32'd0;
         tmo_ff        <= 16'd0;
         err_ff        <= 1'b0;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         stage_ff      <= stage_in;
         hidx_ff       <= hidx_in;
         didx_ff       <= didx_in;
         sum_ff        <= sum_in;
         start_ff      <= start_in;
         tmo_ff        <= tmo_in;
         err_ff        <= err_in;
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         snap_ff <= snap_in;
      end
      if (snap_adv) begin
         rsp_ff <= rsp_in;
      end
      if (hs_we) begin
         header_store_ff[hs_waddr] <= rx;
      end
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         data_mem[dm_waddr] <= rx;
      end
      if (dm_re) begin
         dm_rdata_ff <= data_mem[dm_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_char_ff  <= FRAME_CHAR_RESET;
         buffer_size_ff <= BUFFER_SIZE_RESET;
         timeout_ms_ff  <= TIMEOUT_MS_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_FRAME_CHAR:  frame_char_ff  <= csr_pwdata[7:0];
            REG_BUFFER_SIZE: buffer_size_ff <= csr_pwdata[8:0];
            REG_TIMEOUT_MS:  timeout_ms_ff  <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_FRAME_CHAR:  csr_prdata = {24'd0, frame_char_ff};
         REG_BUFFER_SIZE: csr_prdata = {23'd0, buffer_size_ff};
         REG_TIMEOUT_MS:  csr_prdata = {16'd0, timeout_ms_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   `FLPR_ASSERT_IMPLY(a_hidx_bound, clock, reset, 1'b1, hidx_ff <= HIDX_W'(HEADER_SIZE))
   `FLPR_ASSERT_IMPLY(a_didx_bound, clock, reset, 1'b1, didx_ff <= DIDX_W'(BUF_DEPTH))
   `FLPR_ASSERT_IMPLY(a_hdr_full, clock, reset, (stage_ff == ST_DATA) || (stage_ff == ST_READY), hidx_ff == HIDX_W'(HEADER_SIZE))
   `FLPR_ASSERT_NEXT(a_err_sticky, clock, reset, err_ff, err_ff)
   `FLPR_ASSERT_NEXT(a_snap_moves, clock, reset, snap_valid_ff && !rsp_valid_ff, rsp_valid_ff)

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for framed_line_packet_receiver_core: drives byte, restart and store-read items
// through several register settings with random idling on both streams, predicts every
// result in a scoreboard class and compares it field by field. Depends on flpr_pkg and the RTL.

module tb
   import flpr_pkg::*;
();

   localparam int HDR_SIZE = 8;
   localparam int DEPTH    = 256;

   typedef enum int {FLAW_NONE, FLAW_NEWLINE, FLAW_REFRAME, FLAW_STALL} flaw_type;

   class packet_scoreboard;
      logic [7:0]     fchar;
      logic [8:0]     bsize;
      logic [15:0]    tmo;
      logic [1:0]     stage;
      logic [7:0]     hdr_mem [HDR_SIZE];
      logic [7:0]     dat_mem [DEPTH];
      bit             hdr_ok [HDR_SIZE];
      bit             dat_ok [DEPTH];
      logic [3:0]     hdr_idx;
      logic [8:0]     dat_idx;
      logic [15:0]    sum;
      logic [31:0]    t_start;
      logic [15:0]    timeouts;
      logic           err;
      rsp_fields_type pending_rsp [$];
      int             items;
      int             checked;
      int             errors;
      int             frames;
      int             expiries;

      function new();
         fchar    = FRAME_CHAR_RESET;
         bsize    = BUFFER_SIZE_RESET;
         tmo      = TIMEOUT_MS_RESET;
         stage    = STAGE_CODE_LOOKING;
         hdr_idx  = '0;
         dat_idx  = '0;
         sum      = '0;
         t_start  = '0;
         timeouts = '0;
         err      = 1'b0;
         foreach (hdr_ok[i]) hdr_ok[i] = 1'b0;
         foreach (dat_ok[i]) dat_ok[i] = 1'b0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_FRAME_CHAR:  fchar = value[7:0];
            REG_BUFFER_SIZE: bsize = value[8:0];
            REG_TIMEOUT_MS:  tmo   = value[15:0];
            default: ;
         endcase
      endfunction

      function int data_limit();
         if (bsize == 0) return 1;
         if (bsize > DEPTH) return DEPTH;
         return int'(bsize);
      endfunction

      function void take_item(opcode_type op, logic [7:0] b, logic [31:0] tick,
                              logic [7:0] idx);
         rsp_fields_type r;
         logic [31:0]    elapsed;
         r = '0;
         items++;
         case (op)
            OP_RECEIVE: begin
               if (b == fchar) begin
                  if (stage != STAGE_CODE_LOOKING) err = 1'b1;
                  dat_idx    = '0;
                  stage      = STAGE_CODE_HEADER;
                  hdr_mem[0] = b;
                  hdr_ok[0]  = 1'b1;
                  hdr_idx    = 4'd1;
                  sum        = '0;
                  t_start    = tick;
                  frames++;
               end else begin
                  case (stage)
                     STAGE_CODE_LOOKING: r.pass_byte = b;
                     STAGE_CODE_HEADER: begin
                        if (b == CHAR_LF) begin
                           err   = 1'b1;
                           stage = STAGE_CODE_LOOKING;
                        end else begin
                           if (hdr_idx < HDR_SIZE) begin
                              hdr_mem[hdr_idx] = b;
                              hdr_ok[hdr_idx]  = 1'b1;
                              hdr_idx++;
                              sum += 16'(b);
                           end
                           if (hdr_idx >= HDR_SIZE) begin
                              dat_idx = '0;
                              stage   = STAGE_CODE_DATA;
                           end
                        end
                     end
                     STAGE_CODE_DATA: begin
                        sum += 16'(b);
                        if (dat_idx < DEPTH) begin
                           dat_mem[dat_idx[7:0]] = b;
                           dat_ok[dat_idx[7:0]]  = 1'b1;
                           dat_idx++;
                        end
                        if (b == CHAR_LF || b == CHAR_CR || dat_idx >= data_limit())
                           stage = STAGE_CODE_READY;
                     end
                     default: ;
                  endcase
                  if (stage == STAGE_CODE_HEADER || stage == STAGE_CODE_DATA) begin
                     elapsed = tick - t_start;
                     if (elapsed > tmo) begin
                        if (timeouts != 16'hFFFF) timeouts++;
                        stage = STAGE_CODE_LOOKING;
                        expiries++;
                     end
                  end
               end
            end
            OP_RESTART: begin
               hdr_idx  = '0;
               dat_idx  = '0;
               sum      = '0;
               stage    = STAGE_CODE_LOOKING;
               timeouts = '0;
            end
            OP_READ_DATA:   r.read_data = dat_mem[idx];
            OP_READ_HEADER: if (idx < HDR_SIZE) r.read_data = hdr_mem[idx[2:0]];
            default: ;
         endcase
         r.stage         = stage;
         r.packet_error  = err;
         r.checksum      = sum;
         r.header_count  = hdr_idx;
         r.data_count    = dat_idx;
         r.timeout_count = timeouts;
         pending_rsp.push_back(r);
      endfunction

      function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_fields_type got);
         rsp_fields_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         checked++;
         cmp_field("pass_byte", 16'(want.pass_byte), 16'(got.pass_byte));
         cmp_field("stage", 16'(want.stage), 16'(got.stage));
         cmp_field("packet_error", 16'(want.packet_error), 16'(got.packet_error));
         cmp_field("checksum", want.checksum, got.checksum);
         cmp_field("header_count", 16'(want.header_count), 16'(got.header_count));
         cmp_field("data_count", 16'(want.data_count), 16'(got.data_count));
         cmp_field("timeout_count", want.timeout_count, got.timeout_count);
         cmp_field("read_data", 16'(want.read_data), 16'(got.read_data));
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;  // rx_byte, tick_ms, read_index
   logic [1:0]  req_tuser   = '0;  // opcode
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // pass_byte, stage, packet_error, checksum, header_count, data_count,
   // timeout_count, read_data
   logic [63:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   packet_scoreboard sb = new();
   bit          quiet      = 1'b0;
   int          stall_left = 0;
   logic [31:0] now_tick;

   framed_line_packet_receiver_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_fields_type'(rsp_tdata));
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(opcode_type op, logic [7:0] b, logic [31:0] tick,
                            logic [7:0] idx);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {idx, tick, b};
      do @(posedge clock); while (!req_tready);
      sb.take_item(op, b, tick, idx);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [7:0] fc, logic [8:0] bs, logic [15:0] tm);
      settle();
      csr_write(REG_FRAME_CHAR, {24'd0, fc});
      csr_write(REG_BUFFER_SIZE, {23'd0, bs});
      csr_write(REG_TIMEOUT_MS, {16'd0, tm});
   endtask

   function automatic logic [31:0] step_tick();
      if ($urandom_range(0, 3) == 0) now_tick += $urandom_range(1, 3);
      return now_tick;
   endfunction

   function automatic logic [7:0] body_byte(bit in_data);
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == sb.fchar || b == CHAR_LF || (in_data && b == CHAR_CR));
      return b;
   endfunction

   task automatic send_packet(int len, flaw_type flaw);
      logic [7:0] fc;
      logic [7:0] term;
      int         cut;
      fc   = sb.fchar;
      term = $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
      if (term == fc) term = (term == CHAR_LF) ? CHAR_CR : CHAR_LF;
      cut  = $urandom_range(1, HDR_SIZE - 1);
      send_item(OP_RECEIVE, fc, step_tick(), 8'($urandom));
      for (int k = 1; k < HDR_SIZE; k++) begin
         if (flaw == FLAW_NEWLINE && k == cut) begin
            send_item(OP_RECEIVE, CHAR_LF, step_tick(), 8'($urandom));
            return;
         end
         send_item(OP_RECEIVE, body_byte(1'b0), step_tick(), 8'($urandom));
      end
      if (flaw == FLAW_STALL) now_tick += sb.tmo + 1 + $urandom_range(0, 50);
      for (int k = 0; k < len; k++) begin
         if (flaw == FLAW_REFRAME && k == len / 2) begin
            send_item(OP_RECEIVE, fc, step_tick(), 8'($urandom));
            return;
         end
         send_item(OP_RECEIVE, body_byte(1'b1), step_tick(), 8'($urandom));
      end
      send_item(OP_RECEIVE, term, step_tick(), 8'($urandom));
   endtask

   // touch only entries written since reset; header indexes past the store are always fair
   task automatic read_some(int n);
      logic [7:0] idx;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1)) begin
            idx = 8'($urandom);
            for (int k = 0; k < DEPTH; k++) begin
               if (sb.dat_ok[idx]) break;
               idx++;
            end
            if (sb.dat_ok[idx])
               send_item(OP_READ_DATA, 8'($urandom), $urandom, idx);
            else
               send_item(OP_READ_HEADER, 8'($urandom), $urandom,
                         8'($urandom_range(HDR_SIZE, 255)));
         end else begin
            idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(HDR_SIZE, 255))
                                               : 8'($urandom_range(0, HDR_SIZE - 1));
            if (idx < HDR_SIZE && !sb.hdr_ok[idx]) idx = 8'($urandom_range(HDR_SIZE, 255));
            send_item(OP_READ_HEADER, 8'($urandom), $urandom, idx);
         end
      end
   endtask

   task automatic random_phase(int quota);
      int start;
      int pick;
      int len;
      start = sb.items;
      while (sb.items - start < quota) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         if (pick < 62) begin
            send_packet(len, FLAW_NONE);
            read_some($urandom_range(0, 3));
         end else if (pick < 70) begin
            send_packet(len, FLAW_NEWLINE);
         end else if (pick < 76) begin
            send_packet((len < 2) ? 2 : len, FLAW_REFRAME);
         end else if (pick < 82) begin
            send_packet(len, FLAW_STALL);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 4))
               send_item(OP_RECEIVE, 8'($urandom), $urandom, 8'($urandom));
         end else if (pick < 94) begin
            send_item(OP_RESTART, 8'($urandom), $urandom, 8'($urandom));
         end else begin
            read_some($urandom_range(1, 3));
         end
      end
   endtask

   initial begin
      logic [31:0] t0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, pass-through, restart, framing faults, timeout edge
      now_tick = 32'hFFFF_FFF0;
      send_item(OP_READ_HEADER, 8'h00, 32'h0000_0000, 8'd255);
      send_item(OP_READ_HEADER, 8'hFF, 32'hFFFF_FFFF, 8'd8);
      send_item(OP_RECEIVE, 8'h00, 32'h0000_0000, 8'h00);
      send_item(OP_RECEIVE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
      send_item(OP_RECEIVE, CHAR_LF, $urandom, 8'($urandom));
      send_item(OP_RESTART, 8'h00, $urandom, 8'h00);
      send_packet(2, FLAW_NONE);
      send_item(OP_RECEIVE, 8'h41, step_tick(), 8'h00);
      send_item(OP_READ_HEADER, 8'h00, $urandom, 8'd0);
      send_item(OP_READ_HEADER, 8'h00, $urandom, 8'd7);
      send_item(OP_READ_DATA, 8'h00, $urandom, 8'd0);
      send_item(OP_RECEIVE, FRAME_CHAR_RESET, step_tick(), 8'h00);
      send_item(OP_RECEIVE, CHAR_LF, step_tick(), 8'h00);
      t0 = now_tick;
      send_item(OP_RECEIVE, FRAME_CHAR_RESET, t0, 8'h00);
      send_item(OP_RECEIVE, 8'h41, t0 + 32'(TIMEOUT_MS_RESET), 8'h00);
      send_item(OP_RECEIVE, 8'h42, t0 + 32'(TIMEOUT_MS_RESET) + 32'd1, 8'h00);
      now_tick = t0 + 32'(TIMEOUT_MS_RESET) + 32'd1;
      send_packet(4, FLAW_REFRAME);
      send_item(OP_RESTART, 8'hFF, $urandom, 8'hFF);

      // fill the whole data store once, then read its top entry and a middle one
      send_packet(DEPTH + 4, FLAW_NONE);
      send_item(OP_READ_DATA, 8'($urandom), $urandom, 8'd255);
      send_item(OP_READ_DATA, 8'($urandom), $urandom, 8'd128);
      now_tick = $urandom;
      random_phase(180);

      configure(8'h00, 9'd0, 16'd0);
      random_phase(170);
      configure(8'hFF, 9'd511, 16'hFFFF);
      random_phase(170);
      configure(CHAR_LF, 9'd1, 16'd3);
      random_phase(170);
      configure(8'($urandom), 9'($urandom_range(2, 40)), 16'($urandom_range(20, 400)));
      random_phase(170);
      configure(FRAME_CHAR_RESET, 9'd300, 16'd1000);
      quiet = 1'b1;
      random_phase(150);

      settle();
      repeat (8) @(posedge clock);
      $display("Run covered %0d items under six register settings, %0d results compared.",
               sb.items, sb.checked);
      $display("%0d packets framed, %0d dropped on timeout, %0d mismatches.",
               sb.frames, sb.expiries, sb.errors);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
